### rtl/rmbh_pkg.sv
`default_nettype none

package rmbh_pkg;

  // Fixed field widths.
  localparam int unsigned STEP_W   = 10;
  localparam int unsigned MARGIN_W = 8;
  localparam int unsigned NBOX_W   = 5;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MARCH_STEPS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_MARGIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOXES_IN_USE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ARMED  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0]   MARCH_STEPS_RST  = 10'd300;
  localparam int                  Y_OFFSET_RST     = 5632;
  localparam logic [MARGIN_W-1:0] HIT_MARGIN_RST   = 8'd13;
  localparam logic [NBOX_W-1:0]   BOXES_IN_USE_RST = 5'd0;
  localparam logic                CHECK_ARMED_RST  = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_PREP  = 5'b00100,
    ST_MARCH = 5'b01000,
    ST_DONE  = 5'b10000
  } rmbh_state_e;

  // Commands from the sequencer to the march unit and the box table.
  typedef struct packed {
    logic start_cast;
    logic fetch;
    logic prep;
    logic advance;
  } rmbh_ctl_t;

  // Result handling requests from the sequencer.
  typedef struct packed {
    logic load;
    logic hit;
    logic disarm;
  } rmbh_res_t;

endpackage

`default_nettype wire

### rtl/rmbh_box_table.sv
`default_nettype none

module rmbh_box_table import rmbh_pkg::*; #(
  parameter int unsigned MAX_BOXES  = 16,
  parameter int unsigned COORD_BITS = 20,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [IDX_W-1:0]        wr_addr_i,
  input  logic [3*COORD_BITS-1:0] wr_center_i,
  input  logic [3*COORD_BITS-1:0] wr_size_i,
  input  logic                    wr_armed_i,
  input  logic                    rd_en_i,
  input  logic [IDX_W-1:0]        rd_addr_i,
  input  logic                    disarm_i,
  output logic [3*COORD_BITS-1:0] rd_center_o,
  output logic [3*COORD_BITS-1:0] rd_size_o,
  output logic                    armed_o
);

  localparam int unsigned VEC_W = 3 * COORD_BITS;

  logic [2*VEC_W-1:0]   mem_q [MAX_BOXES];
  logic [2*VEC_W-1:0]   rd_q;
  logic [MAX_BOXES-1:0] armed_q;

  // Box geometry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_size_i, wr_center_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_center_o = rd_q[VEC_W-1:0];
  assign rd_size_o   = rd_q[2*VEC_W-1:VEC_W];

  // Armed bits are flip-flops so that reset clears them at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (wr_en_i) begin
      armed_q[wr_addr_i] <= wr_armed_i;
    end else if (disarm_i) begin
      armed_q[rd_addr_i] <= 1'b0;
    end
  end

  assign armed_o = armed_q[rd_addr_i];

endmodule

`default_nettype wire

### rtl/rmbh_march_unit.sv
`default_nettype none

module rmbh_march_unit import rmbh_pkg::*; #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  rmbh_ctl_t                    ctl_i,
  input  logic [3*COORD_BITS-1:0]      org_i,
  input  logic [3*COORD_BITS-1:0]      dir_i,
  input  logic [3*COORD_BITS-1:0]      center_i,
  input  logic [3*COORD_BITS-1:0]      size_i,
  input  logic signed [COORD_BITS-1:0] y_offset_i,
  input  logic [MARGIN_W-1:0]          hit_margin_i,
  output logic                         hit_o,
  output logic [3*COORD_BITS-1:0]      point_o
);

  localparam int unsigned C = COORD_BITS;

  logic signed [C-1:0] base_q [3];
  logic signed [C-1:0] dir_q  [3];
  logic signed [C-1:0] p_q    [3];
  logic signed [C:0]   cadj_q [3];
  logic signed [C:0]   lim_q  [3];
  logic signed [C+2:0] diff   [3];
  logic signed [C+2:0] lim_x  [3];
  logic [2:0]          in_box;
  logic signed [C:0]   margin2;

  // Twice the margin, as a small positive signed value.
  assign margin2 = (C+1)'($signed({1'b0, hit_margin_i, 1'b0}));

  // Point register and per-box bounds. The Y offset is folded into the
  // Y center, so the test compares the point against adjusted centers.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (ctl_i.start_cast) begin
        base_q[j] <= $signed(org_i[j*C +: C]) + $signed(dir_i[j*C +: C]);
        dir_q[j]  <= $signed(dir_i[j*C +: C]);
      end
      if (ctl_i.prep) begin
        p_q[j]   <= base_q[j] + dir_q[j];
        lim_q[j] <= (C+1)'($signed(size_i[j*C +: C])) + margin2;
        if (j == 1) begin
          cadj_q[j] <= (C+1)'($signed(center_i[j*C +: C])) - (C+1)'(y_offset_i);
        end else begin
          cadj_q[j] <= (C+1)'($signed(center_i[j*C +: C]));
        end
      end else if (ctl_i.advance) begin
        p_q[j] <= p_q[j] + dir_q[j];
      end
    end
  end

  // Strict inside test per axis: |2(p - c)| < s + 2m.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j]   = ((C+3)'(p_q[j]) - (C+3)'(cadj_q[j])) <<< 1;
      lim_x[j]  = (C+3)'(lim_q[j]);
      in_box[j] = (diff[j] < lim_x[j]) && ((-diff[j]) < lim_x[j]);
    end
  end

  assign hit_o   = &in_box;
  assign point_o = {p_q[2], p_q[1], p_q[0]};

endmodule

`default_nettype wire

### rtl/rmbh_ctrl.sv
`default_nettype none

module rmbh_ctrl import rmbh_pkg::*; #(
  parameter int unsigned MAX_BOXES = 16,
  parameter int unsigned CNT_W     = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              cmd_i,
  output logic              in_ready_o,
  input  logic [STEP_W-1:0] march_steps_i,
  input  logic [NBOX_W-1:0] boxes_in_use_i,
  input  logic              check_armed_i,
  input  logic              armed_i,
  input  logic              hit_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  output rmbh_ctl_t         ctl_o,
  output rmbh_res_t         res_o,
  output logic [CNT_W-1:0]  cnt_o,
  output logic [STEP_W-1:0] step_o
);

  rmbh_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STEP_W-1:0] k_q, k_d;
  logic              hit_q, hit_d;
  logic              box_ok;
  logic              skip_box;

  // Box index is within the boxes in use and within the table.
  assign box_ok   = (int'(cnt_q) < int'(boxes_in_use_i)) && (int'(cnt_q) < MAX_BOXES);
  assign skip_box = (check_armed_i && !armed_i) || (march_steps_i == '0);

  // Sequencer: walk boxes, then march each tested box one step a cycle.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    hit_d      = hit_q;
    ctl_o      = '0;
    res_o      = '0;
    res_o.hit  = hit_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (cmd_i == CMD_CAST)) begin
          ctl_o.start_cast = 1'b1;
          cnt_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!box_ok) begin
          state_d = ST_DONE;
        end else if (skip_box) begin
          cnt_d = CNT_W'(cnt_q + 1'b1);
        end else begin
          ctl_o.fetch = 1'b1;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        ctl_o.prep = 1'b1;
        k_d     = '0;
        state_d = ST_MARCH;
      end
      ST_MARCH: begin
        if (hit_i) begin
          hit_d        = 1'b1;
          res_o.disarm = check_armed_i;
          state_d      = ST_DONE;
        end else if (k_q == march_steps_i - 1'b1) begin
          cnt_d   = CNT_W'(cnt_q + 1'b1);
          state_d = ST_SCAN;
        end else begin
          k_d = k_q + 1'b1;
          ctl_o.advance = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_i || out_ready_i) begin
          res_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      hit_q   <= hit_d;
    end
  end

  assign cnt_o  = cnt_q;
  assign step_o = k_q;

endmodule

`default_nettype wire

### rtl/ray_march_box_hit_test_unit.sv
// Ray march box hit test.
// Input channel (in_valid_i/in_ready_o): a beat is a load or a cast. A load
// writes one box (center, size, armed bit) into the table and gives no
// result. A cast marches a ray through the boxes in use in table order and
// gives exactly one result beat on the output channel
// (out_valid_o/out_ready_i), with the first box hit or a miss.
// For each box a cast either skips it or fetches its geometry, prepares the
// bounds and marches it. The march unit tests one point per cycle. The
// block takes no new beat while a cast runs; it takes the next beat while
// a result waits.
// Configuration (cfg_valid_i/cfg_ready_o) is always ready and must only be
// written while the block is idle.
// Reset clears the armed bits and restores the register defaults; box
// geometry is undefined until loaded. A stalled receiver holds the result
// register, and a finished cast waits for it before the block goes idle.
`default_nettype none

module ray_march_box_hit_test_unit import rmbh_pkg::*; #(
  parameter int unsigned MAX_BOXES  = 16,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [SLOT_W-1:0]            box_slot_i,
  input  logic signed [COORD_BITS-1:0] vec_a_x_i,
  input  logic signed [COORD_BITS-1:0] vec_a_y_i,
  input  logic signed [COORD_BITS-1:0] vec_a_z_i,
  input  logic signed [COORD_BITS-1:0] vec_b_x_i,
  input  logic signed [COORD_BITS-1:0] vec_b_y_i,
  input  logic signed [COORD_BITS-1:0] vec_b_z_i,
  input  logic                         armed_flag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         was_hit_o,
  output logic [SLOT_W-1:0]            hit_slot_o,
  output logic [STEP_W-1:0]            hit_step_o,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic signed [COORD_BITS-1:0] point_z_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

  logic [STEP_W-1:0]   march_steps_q;
  logic signed [C-1:0] y_offset_q;
  logic [MARGIN_W-1:0] hit_margin_q;
  logic [NBOX_W-1:0]   boxes_in_use_q;
  logic                check_armed_q;

  rmbh_ctl_t         ctl;
  rmbh_res_t         res;
  logic [CNT_W-1:0]  cnt;
  logic [STEP_W-1:0] step;
  logic              armed;
  logic              hit;
  logic              load_wr;
  logic [3*C-1:0]    org;
  logic [3*C-1:0]    dir;
  logic [3*C-1:0]    rd_center;
  logic [3*C-1:0]    rd_size;
  logic [3*C-1:0]    point;

  logic                out_valid_q;
  logic                was_hit_q;
  logic [SLOT_W-1:0]   hit_slot_q;
  logic [STEP_W-1:0]   hit_step_q;
  logic signed [C-1:0] point_x_q;
  logic signed [C-1:0] point_y_q;
  logic signed [C-1:0] point_z_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      march_steps_q  <= MARCH_STEPS_RST;
      y_offset_q     <= C'(Y_OFFSET_RST);
      hit_margin_q   <= HIT_MARGIN_RST;
      boxes_in_use_q <= BOXES_IN_USE_RST;
      check_armed_q  <= CHECK_ARMED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MARCH_STEPS:  march_steps_q  <= cfg_data_i[STEP_W-1:0];
        CFG_Y_OFFSET:     y_offset_q     <= $signed(cfg_data_i);
        CFG_HIT_MARGIN:   hit_margin_q   <= cfg_data_i[MARGIN_W-1:0];
        CFG_BOXES_IN_USE: boxes_in_use_q <= cfg_data_i[NBOX_W-1:0];
        CFG_CHECK_ARMED:  check_armed_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A load beat writes the table when its slot exists.
  assign load_wr = in_valid_i && in_ready_o && (cmd_i == CMD_LOAD) &&
                   (int'(box_slot_i) < MAX_BOXES);
  assign org = {vec_a_z_i, vec_a_y_i, vec_a_x_i};
  assign dir = {vec_b_z_i, vec_b_y_i, vec_b_x_i};

  rmbh_ctrl #(
    .MAX_BOXES (MAX_BOXES),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .cmd_i          (cmd_i),
    .in_ready_o     (in_ready_o),
    .march_steps_i  (march_steps_q),
    .boxes_in_use_i (boxes_in_use_q),
    .check_armed_i  (check_armed_q),
    .armed_i        (armed),
    .hit_i          (hit),
    .out_valid_i    (out_valid_q),
    .out_ready_i    (out_ready_i),
    .ctl_o          (ctl),
    .res_o          (res),
    .cnt_o          (cnt),
    .step_o         (step)
  );

  rmbh_box_table #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_box_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (load_wr),
    .wr_addr_i   (IDX_W'(box_slot_i)),
    .wr_center_i (org),
    .wr_size_i   (dir),
    .wr_armed_i  (armed_flag_i),
    .rd_en_i     (ctl.fetch),
    .rd_addr_i   (cnt[IDX_W-1:0]),
    .disarm_i    (res.disarm),
    .rd_center_o (rd_center),
    .rd_size_o   (rd_size),
    .armed_o     (armed)
  );

  rmbh_march_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_march_unit (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .org_i        (org),
    .dir_i        (dir),
    .center_i     (rd_center),
    .size_i       (rd_size),
    .y_offset_i   (y_offset_q),
    .hit_margin_i (hit_margin_q),
    .hit_o        (hit),
    .point_o      (point)
  );

  // Result register: holds a beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      was_hit_q  <= res.hit;
      hit_slot_q <= res.hit ? SLOT_W'(cnt) : '0;
      hit_step_q <= res.hit ? step : '0;
      point_x_q  <= res.hit ? $signed(point[0*C +: C]) : '0;
      point_y_q  <= res.hit ? $signed(point[1*C +: C]) : '0;
      point_z_q  <= res.hit ? $signed(point[2*C +: C]) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign was_hit_o   = was_hit_q;
  assign hit_slot_o  = hit_slot_q;
  assign hit_step_o  = hit_step_q;
  assign point_x_o   = point_x_q;
  assign point_y_o   = point_y_q;
  assign point_z_o   = point_z_q;

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rmbh_pkg::*;

  localparam int CW         = 20;
  localparam int NBOX       = 16;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_LEN   = 1500;
  localparam int PRINT_CAP  = 100;

  // One input beat: a box load or a ray cast.
  typedef struct {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic              armed;
  } march_beat_t;

  // One result beat.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [STEP_W-1:0] step;
    logic [CW-1:0]     px, py, pz;
  } hit_report_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Stimulus side.
  march_beat_t cur = '{cmd: CMD_LOAD, slot: '0, ax: '0, ay: '0, az: '0,
                       bx: '0, by: '0, bz: '0, armed: 1'b0};
  logic in_valid = 1'b0;
  logic in_took = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  logic in_ready, out_valid, cfg_ready, was_hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [STEP_W-1:0] hit_step;
  logic signed [CW-1:0] point_x, point_y, point_z;

  march_beat_t ray_cmds[$];
  hit_report_t hits_due[$];
  hit_report_t want;

  // Predicted register file and box table.
  int unsigned cfg_steps  = MARCH_STEPS_RST;
  longint      cfg_yoff   = Y_OFFSET_RST;
  int unsigned cfg_margin = HIT_MARGIN_RST;
  int unsigned cfg_boxes  = BOXES_IN_USE_RST;
  bit          cfg_check  = CHECK_ARMED_RST;
  longint ctr_tbl[NBOX][3];
  longint size_tbl[NBOX][3];
  bit     armed_tbl[NBOX];
  // Box centers as the stimulus generator will have loaded them.
  longint plan_ctr[NBOX][3];

  bit calm = 1'b0;
  bit stall_phase = 1'b0;
  bit stall_done = 1'b0;
  int ready_hold = 0;

  int err_cnt = 0;
  int res_cnt = 0;
  int hit_cnt = 0;
  int load_cnt = 0;
  int cast_cnt = 0;
  int setting_cnt = 0;
  int cycle_cnt = 0;

  ray_march_box_hit_test_unit #(
    .MAX_BOXES (NBOX),
    .COORD_BITS(CW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cur.cmd),
    .box_slot_i  (cur.slot),
    .vec_a_x_i   (cur.ax),
    .vec_a_y_i   (cur.ay),
    .vec_a_z_i   (cur.az),
    .vec_b_x_i   (cur.bx),
    .vec_b_y_i   (cur.by),
    .vec_b_z_i   (cur.bz),
    .armed_flag_i(cur.armed),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .was_hit_o   (was_hit),
    .hit_slot_o  (hit_slot),
    .hit_step_o  (hit_step),
    .point_x_o   (point_x),
    .point_y_o   (point_y),
    .point_z_o   (point_z),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sign-extends the low coordinate bits, the way the marched point wraps.
  function automatic longint wrap_coord(input longint v);
    logic [CW-1:0] t;
    t = v[CW-1:0];
    return longint'($signed(t));
  endfunction

  // Strict test against one axis of a box grown by the margin.
  function automatic bit on_axis(input longint p, input longint c, input longint s);
    longint d, lim;
    d = 2 * (p - c);
    lim = s + 2 * longint'(cfg_margin);
    return (d < lim) && (-d < lim);
  endfunction

  // Marches the ray through the boxes in use and returns the first hit.
  function automatic hit_report_t trace_ray(input march_beat_t b);
    hit_report_t r;
    longint org[3], dir[3], p[3];
    int unsigned n;
    r = '0;
    org[0] = b.ax;
    org[1] = b.ay;
    org[2] = b.az;
    dir[0] = b.bx;
    dir[1] = b.by;
    dir[2] = b.bz;
    n = (cfg_boxes > NBOX) ? NBOX : cfg_boxes;
    for (int i = 0; i < n; i++) begin
      if (cfg_check && !armed_tbl[i]) continue;
      for (int j = 0; j < 3; j++) p[j] = wrap_coord(org[j] + dir[j]);
      for (int k = 0; k < cfg_steps; k++) begin
        for (int j = 0; j < 3; j++) p[j] = wrap_coord(p[j] + dir[j]);
        if (on_axis(p[0], ctr_tbl[i][0], size_tbl[i][0]) &&
            on_axis(p[2], ctr_tbl[i][2], size_tbl[i][2]) &&
            on_axis(p[1] + cfg_yoff, ctr_tbl[i][1], size_tbl[i][1])) begin
          if (cfg_check) armed_tbl[i] = 1'b0;
          r.hit  = 1'b1;
          r.slot = SLOT_W'(i);
          r.step = STEP_W'(k);
          r.px   = p[0][CW-1:0];
          r.py   = p[1][CW-1:0];
          r.pz   = p[2][CW-1:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic longint rand_coord();
    logic [CW-1:0] t;
    t = CW'($urandom());
    return longint'($signed(t));
  endfunction

  function automatic longint rand_near(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  task automatic flag_mismatch(input string what);
    if (err_cnt < PRINT_CAP) $display("mismatch at result %0d: %s", res_cnt, what);
    err_cnt++;
  endtask

  // Queues a load beat and tracks where the box will sit.
  task automatic push_load(input int slot, input longint cx, input longint cy,
                           input longint cz, input longint sx, input longint sy,
                           input longint sz, input bit armed);
    march_beat_t b;
    b.cmd = CMD_LOAD;
    b.slot = SLOT_W'(slot);
    b.ax = CW'(cx);
    b.ay = CW'(cy);
    b.az = CW'(cz);
    b.bx = CW'(sx);
    b.by = CW'(sy);
    b.bz = CW'(sz);
    b.armed = armed;
    plan_ctr[slot][0] = wrap_coord(cx);
    plan_ctr[slot][1] = wrap_coord(cy);
    plan_ctr[slot][2] = wrap_coord(cz);
    ray_cmds.insert(ray_cmds.size(), b);
  endtask

  // Queues a cast beat; the slot and armed fields carry noise.
  task automatic push_cast(input longint ox, input longint oy, input longint oz,
                           input longint dx, input longint dy, input longint dz);
    march_beat_t b;
    b.cmd = CMD_CAST;
    b.slot = SLOT_W'($urandom());
    b.ax = CW'(ox);
    b.ay = CW'(oy);
    b.az = CW'(oz);
    b.bx = CW'(dx);
    b.by = CW'(dy);
    b.bz = CW'(dz);
    b.armed = 1'($urandom());
    ray_cmds.insert(ray_cmds.size(), b);
  endtask

  // Queues a cast whose test number k lands on the center of a box,
  // shifted along X by off.
  task automatic push_aimed(input int slot, input int k, input longint dx,
                            input longint dy, input longint dz, input longint off);
    longint reach;
    reach = longint'(k + 2);
    push_cast(plan_ctr[slot][0] + off - reach * dx,
              plan_ctr[slot][1] - cfg_yoff - reach * dy,
              plan_ctr[slot][2] - reach * dz, dx, dy, dz);
  endtask

  // Waits until every beat is taken and every result is back, then lets
  // a trailing load finish.
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (ray_cmds.size() != 0 || in_valid || hits_due.size() != 0);
    repeat (10) @(posedge clk_i);
    #1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_MARCH_STEPS:  cfg_steps = data[STEP_W-1:0];
      CFG_Y_OFFSET:     cfg_yoff = longint'($signed(data));
      CFG_HIT_MARGIN:   cfg_margin = data[MARGIN_W-1:0];
      CFG_BOXES_IN_USE: cfg_boxes = data[NBOX_W-1:0];
      CFG_CHECK_ARMED:  cfg_check = data[0];
      default: ;
    endcase
  endtask

  // Brings the block to idle and writes the whole register file.
  task automatic set_regs(input int unsigned steps, input longint yoff,
                          input int unsigned margin, input int unsigned boxes,
                          input bit check);
    settle();
    write_reg(CFG_MARCH_STEPS, CW'(steps));
    write_reg(CFG_Y_OFFSET, CW'(yoff));
    write_reg(CFG_HIT_MARGIN, CW'(margin));
    write_reg(CFG_BOXES_IN_USE, CW'(boxes));
    write_reg(CFG_CHECK_ARMED, CW'(check));
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    setting_cnt++;
  endtask

  // A phase under a random setting: mostly casts aimed at loaded boxes,
  // with reloads that rearm boxes and some free-running rays.
  task automatic random_phase(input int count, input bit quiet, input bit squeeze);
    int unsigned span, pick;
    bit wide;
    set_regs($urandom_range(1, 40),
             ($urandom_range(1) != 0) ? rand_coord() : rand_near(2048),
             $urandom_range(0, 255), $urandom_range(0, 20), $urandom_range(0, 1));
    calm = quiet;
    stall_phase = squeeze;
    span = (cfg_boxes > NBOX) ? NBOX : cfg_boxes;
    repeat (count) begin
      pick = $urandom_range(99);
      wide = ($urandom_range(9) == 0);
      if (pick < 30) begin
        push_load($urandom_range(0, NBOX - 1),
                  wide ? rand_coord() : rand_near(65536),
                  wide ? rand_coord() : rand_near(65536),
                  wide ? rand_coord() : rand_near(65536),
                  wide ? rand_coord() : longint'($urandom_range(256, 8191)),
                  wide ? rand_coord() : longint'($urandom_range(256, 8191)),
                  wide ? rand_coord() : longint'($urandom_range(256, 8191)),
                  $urandom_range(4) != 0);
      end else if (pick < 78 && span != 0) begin
        push_aimed($urandom_range(0, span - 1), $urandom_range(0, cfg_steps - 1),
                   rand_near(200), rand_near(200), rand_near(200),
                   ($urandom_range(3) == 0) ? rand_near(300) : 0);
      end else begin
        push_cast(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  // Input driver: offers the next pending beat once the last one is taken.
  always @(negedge clk_i) begin
    if (!in_valid || in_took) begin
      if (ray_cmds.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
        cur <= ray_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accepted input beats update the predicted table or queue a hit report.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      if (cur.cmd == CMD_LOAD) begin
        ctr_tbl[cur.slot][0] = cur.ax;
        ctr_tbl[cur.slot][1] = cur.ay;
        ctr_tbl[cur.slot][2] = cur.az;
        size_tbl[cur.slot][0] = cur.bx;
        size_tbl[cur.slot][1] = cur.by;
        size_tbl[cur.slot][2] = cur.bz;
        armed_tbl[cur.slot] = cur.armed;
        load_cnt++;
      end else begin
        hits_due.insert(hits_due.size(), trace_ray(cur));
        cast_cnt++;
      end
    end
    in_took <= rst_ni && in_valid && in_ready;
  end

  // Receiver ready: random gaps, plus one long hold-off in the pressure phase.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (stall_phase && !stall_done && out_valid) begin
      ready_hold <= HOLD_LEN;
      stall_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 23;
    end
  end

  // Result monitor: each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        flag_mismatch("result beat with no cast outstanding");
      end else begin
        want = hits_due.pop_front();
        if (was_hit !== want.hit)
          flag_mismatch($sformatf("was_hit %0b, expected %0b", was_hit, want.hit));
        if (hit_slot !== want.slot)
          flag_mismatch($sformatf("hit_slot %0d, expected %0d", hit_slot, want.slot));
        if (hit_step !== want.step)
          flag_mismatch($sformatf("hit_step %0d, expected %0d", hit_step, want.step));
        if (point_x !== want.px)
          flag_mismatch($sformatf("point_x %h, expected %h", point_x, want.px));
        if (point_y !== want.py)
          flag_mismatch($sformatf("point_y %h, expected %h", point_y, want.py));
        if (point_z !== want.pz)
          flag_mismatch($sformatf("point_z %h, expected %h", point_z, want.pz));
        if (want.hit) hit_cnt++;
      end
      res_cnt++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL ray_march_box_hit_test_unit");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #1;

    // Reset settings: fill the table with spaced boxes. Slot 3 is unarmed,
    // slot 5 is empty through negative sizes, slot 15 sits at the corners.
    for (int i = 0; i < NBOX - 1; i++) begin
      if (i == 5)
        push_load(i, i * 4096 - 32768, i * 2048, -i * 3072, -1024, 1024, -524288, 1'b1);
      else
        push_load(i, i * 4096 - 32768, i * 2048, -i * 3072, 512, 512, 512, i != 3);
    end
    push_load(NBOX - 1, 524287, -524288, 0, 524287, 1024, 1024, 1'b1);
    // No boxes in use: the cast misses.
    push_cast(1000, -1000, 77, 16, 16, 16);

    set_regs(20, 0, 0, 16, 1'b1);
    push_aimed(0, 0, 16, -8, 4, 0);
    // Box 0 is now disarmed and gets skipped.
    push_aimed(0, 5, 16, -8, 4, 0);
    push_aimed(1, 19, -32, 7, 100, 0);
    push_aimed(3, 2, 9, 9, 9, 0);
    push_aimed(5, 1, 3, -3, 3, 0);
    // Just inside, then exactly on, the face of a box with no margin.
    push_aimed(2, 0, 0, 0, 0, 255);
    push_aimed(4, 0, 0, 0, 0, 256);
    push_cast(524287, 524287, 524287, -524288, -524288, -524288);
    push_cast(-524288, -524288, -524288, 524287, 524287, 524287);

    // Armed checking off, too many boxes, a single step, widest margin.
    set_regs(1, -4096, 255, 31, 1'b0);
    push_aimed(6, 0, 1, 1, 1, 0);
    push_aimed(3, 0, -5, 2, 0, 0);
    push_aimed(0, 0, 0, 0, 0, 0);
    push_aimed(15, 0, 0, 0, 0, 0);

    // No steps at all.
    set_regs(0, 524287, 0, 16, 1'b1);
    push_aimed(2, 0, 0, 0, 0, 0);

    // Longest march, reaching the last step of the last box.
    set_regs(1023, -524288, 13, 16, 1'b1);
    push_aimed(15, 1022, 1, 0, -1, 0);
    push_aimed(15, 1022, 1, 0, -1, 0);

    random_phase(14, 1'b0, 1'b0);
    random_phase(14, 1'b1, 1'b0);
    random_phase(24, 1'b0, 1'b1);
    random_phase(12, 1'b0, 1'b0);
    random_phase(12, 1'b0, 1'b0);
    random_phase(12, 1'b0, 1'b0);

    settle();
    repeat (40) @(posedge clk_i);
    $display("ran %0d loads and %0d casts (%0d hits) under %0d register settings",
             load_cnt, cast_cnt, hit_cnt, setting_cnt);
    $display("%0d results checked, %0d mismatches, %0d cycles",
             res_cnt, err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("PASS ray_march_box_hit_test_unit");
    end else begin
      $display("FAIL ray_march_box_hit_test_unit");
    end
    $finish;
  end

endmodule
